// ===== rtl/core/fac_pkg.sv =====
`timescale 1ns / 1ps
package fac_pkg;

  localparam int NUM_ROWS   = 4;
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int ROW_W      = 64;
  localparam int COEF_W     = 16;
  localparam int BOX_W      = 16;
  localparam int IDX_W      = 8;

  // plane coefficient: sum of two q4.12 values
  localparam int NRM_W      = COEF_W + 1;
  localparam int NABS_W     = NRM_W;
  // 2d in 2^-16 units is d shifted left by five
  localparam int OFS_SHIFT  = 5;
  localparam int OFS_W      = NRM_W + OFS_SHIFT;

  // min+max and |max-min|
  localparam int SUM_W      = BOX_W + 1;
  localparam int EXT_W      = BOX_W;

  localparam int PROD_W     = NRM_W + SUM_W;
  localparam int UPROD_W    = NABS_W + EXT_W;
  localparam int LHS_W      = PROD_W + 3;
  localparam int RHS_W      = UPROD_W + 2;
  localparam int TOT_W      = LHS_W + 1;

  localparam int QUEUE_DEPTH_DEF = 4;

  // row that every plane is built around
  localparam int BASE_ROW   = NUM_ROWS - 1;

  typedef struct packed {
    logic [NUM_AXES-1:0][SUM_W-1:0] sum2;
    logic [NUM_AXES-1:0][EXT_W-1:0] ext2;
    logic [NUM_PLANES-1:0]          enable;
  } box_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][NRM_W-1:0]  nrm;
    logic [NUM_AXES-1:0][NABS_W-1:0] nabs;
    logic [OFS_W-1:0]                ofs;
  } plane_t;

endpackage

// ===== rtl/core/fac_plane.sv =====
`timescale 1ns / 1ps
module fac_plane (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [fac_pkg::IDX_W-1:0]               cfg_index,
  input  logic [fac_pkg::ROW_W-1:0]               cfg_data,
  output fac_pkg::plane_t [fac_pkg::NUM_PLANES-1:0] planes
);
  import fac_pkg::*;

  logic [ROW_W-1:0] rows [NUM_ROWS];
  plane_t [NUM_PLANES-1:0] planes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows[r] <= '0;
      end
    end else if (cfg_write && (cfg_index < IDX_W'(NUM_ROWS))) begin
      rows[cfg_index[$clog2(NUM_ROWS)-1:0]] <= cfg_data;
    end
  end

  // planes are row3 plus or minus one of rows 0..2
  always_comb begin
    logic signed [COEF_W-1:0] base;
    logic signed [COEF_W-1:0] side;
    logic signed [NRM_W-1:0]  sum;
    planes_next = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        base = $signed(rows[BASE_ROW][a*COEF_W +: COEF_W]);
        side = $signed(rows[p >> 1][a*COEF_W +: COEF_W]);
        sum  = ((p & 1) != 0) ? NRM_W'(base) - NRM_W'(side) : NRM_W'(base) + NRM_W'(side);
        planes_next[p].nrm[a]  = sum;
        planes_next[p].nabs[a] = sum[NRM_W-1] ? NABS_W'(-sum) : NABS_W'(sum);
      end
      base = $signed(rows[BASE_ROW][NUM_AXES*COEF_W +: COEF_W]);
      side = $signed(rows[p >> 1][NUM_AXES*COEF_W +: COEF_W]);
      sum  = ((p & 1) != 0) ? NRM_W'(base) - NRM_W'(side) : NRM_W'(base) + NRM_W'(side);
      planes_next[p].ofs = {sum, OFS_SHIFT'(0)};
    end
  end

  always_ff @(posedge clk) begin
    planes <= planes_next;
  end

endmodule

// ===== rtl/core/fac_front.sv =====
`timescale 1ns / 1ps
module fac_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              box_valid,
  output logic                              box_stall,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_min_x,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_min_y,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_min_z,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_max_x,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_max_y,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_max_z,
  input  logic [fac_pkg::NUM_PLANES-1:0]    plane_enable,
  input  logic                              q_full,
  output logic                              push,
  output fac_pkg::box_t                     item
);
  import fac_pkg::*;

  logic signed [BOX_W-1:0] lo [NUM_AXES];
  logic signed [BOX_W-1:0] hi [NUM_AXES];
  box_t item_next;
  logic front_valid;

  assign lo[0] = box_min_x;
  assign lo[1] = box_min_y;
  assign lo[2] = box_min_z;
  assign hi[0] = box_max_x;
  assign hi[1] = box_max_y;
  assign hi[2] = box_max_z;

  // doubled center and doubled extent, extent taken as magnitude
  always_comb begin
    logic signed [SUM_W-1:0] diff;
    item_next = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      item_next.sum2[a] = SUM_W'(lo[a]) + SUM_W'(hi[a]);
      diff = SUM_W'(hi[a]) - SUM_W'(lo[a]);
      item_next.ext2[a] = diff[SUM_W-1] ? EXT_W'(-diff) : EXT_W'(diff);
    end
    item_next.enable = plane_enable;
  end

  assign box_stall = front_valid & q_full;
  assign push      = front_valid & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (!box_stall) begin
      front_valid <= box_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!box_stall && box_valid) begin
      item <= item_next;
    end
  end

endmodule

// ===== rtl/core/fac_queue.sv =====
`timescale 1ns / 1ps
module fac_queue #(
  parameter int QUEUE_DEPTH = fac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fac_pkg::box_t push_item,
  input  logic          pop,
  output fac_pkg::box_t head,
  output logic          not_empty,
  output logic          full
);
  import fac_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  box_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/fac_back.sv =====
`timescale 1ns / 1ps
module fac_back (
  input  logic                                      clk,
  input  logic                                      rst,
  input  fac_pkg::plane_t [fac_pkg::NUM_PLANES-1:0] planes,
  input  fac_pkg::box_t                             head,
  input  logic                                      head_valid,
  output logic                                      pop,
  output logic                                      result_valid,
  input  logic                                      result_stall,
  output logic                                      inside_res
);
  import fac_pkg::*;

  logic advance;

  logic                        s1_valid;
  logic [NUM_PLANES-1:0]       s1_en;
  logic signed [PROD_W-1:0]    s1_prod_s [NUM_PLANES][NUM_AXES];
  logic [UPROD_W-1:0]          s1_prod_u [NUM_PLANES][NUM_AXES];

  logic                        s2_valid;
  logic [NUM_PLANES-1:0]       s2_en;
  logic signed [LHS_W-1:0]     s2_lhs [NUM_PLANES];
  logic [RHS_W-1:0]            s2_rhs [NUM_PLANES];

  logic [TOT_W-1:0]            tot [NUM_PLANES];
  logic [NUM_PLANES-1:0]       pass;

  // whole back pipeline moves unless the result register is held
  assign advance = ~(result_valid & result_stall);
  assign pop     = advance & head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= head_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  // products of plane normal with doubled center and doubled extent
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_en <= head.enable;
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          s1_prod_s[p][a] <= $signed(planes[p].nrm[a]) * $signed(head.sum2[a]);
          s1_prod_u[p][a] <= planes[p].nabs[a] * head.ext2[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_en <= s1_en;
      for (int p = 0; p < NUM_PLANES; p++) begin
        s2_lhs[p] <= LHS_W'(s1_prod_s[p][0]) + LHS_W'(s1_prod_s[p][1])
                   + LHS_W'(s1_prod_s[p][2]) + LHS_W'($signed(planes[p].ofs));
        s2_rhs[p] <= RHS_W'(s1_prod_u[p][0]) + RHS_W'(s1_prod_u[p][1])
                   + RHS_W'(s1_prod_u[p][2]);
      end
    end
  end

  // lhs >= -rhs  <=>  lhs + rhs >= 0
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      tot[p]  = TOT_W'(s2_lhs[p]) + TOT_W'(s2_rhs[p]);
      pass[p] = ~s2_en[p] | ~tot[p][TOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside_res <= &pass;
    end
  end

endmodule

// ===== rtl/core/frustum_aabb_cull_test.sv =====
// path: box request into the front register, then the queue, s1, s2 and the inside_res register
// throughput: one box per cycle unless box_stall; a 4-deep queue lets the front keep taking
//   boxes while the result side stalls, and the input stalls only once that queue is full
// reset: synchronous, active high; clears matrix rows to zero and all valid and queue state
// a matrix row write goes into the row registers and from there into the plane registers
`timescale 1ns / 1ps
module frustum_aabb_cull_test #(
  parameter int QUEUE_DEPTH = fac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel: matrix rows 0..3
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fac_pkg::IDX_W-1:0]         cfg_index,
  input  logic [fac_pkg::ROW_W-1:0]         cfg_data,
  // box request channel
  input  logic                              box_valid,
  output logic                              box_stall,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_min_x,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_min_y,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_min_z,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_max_x,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_max_y,
  input  logic signed [fac_pkg::BOX_W-1:0]  box_max_z,
  input  logic [fac_pkg::NUM_PLANES-1:0]    plane_enable,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              inside_res
);
  import fac_pkg::*;

  plane_t [NUM_PLANES-1:0] planes;
  box_t                    front_item;
  box_t                    q_head;
  logic                    front_push;
  logic                    q_full;
  logic                    q_not_empty;
  logic                    back_pop;

  // row registers are always writable
  assign cfg_ready = 1'b1;

  // matrix rows and the six derived planes, registered
  fac_plane u_plane (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // front: takes the box request, forms doubled center and extent
  fac_front u_front (
    .clk          (clk),
    .rst          (rst),
    .box_valid    (box_valid),
    .box_stall    (box_stall),
    .box_min_x    (box_min_x),
    .box_min_y    (box_min_y),
    .box_min_z    (box_min_z),
    .box_max_x    (box_max_x),
    .box_max_y    (box_max_y),
    .box_max_z    (box_max_z),
    .plane_enable (plane_enable),
    .q_full       (q_full),
    .push         (front_push),
    .item         (front_item)
  );

  // short queue decoupling front from the plane pipeline
  fac_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_item (front_item),
    .pop       (back_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // back: multiply, sum, compare per plane, then and over enabled planes
  fac_back u_back (
    .clk          (clk),
    .rst          (rst),
    .planes       (planes),
    .head         (q_head),
    .head_valid   (q_not_empty),
    .pop          (back_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .inside_res   (inside_res)
  );

endmodule

// ===== rtl/core/fac_checker.sv =====
`timescale 1ns / 1ps
module fac_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic                      box_valid,
  input logic                      box_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic                      inside_res
);

  // held result stays put
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(inside_res))
    else $error("held result changed");

  // reset empties the pipeline and frees the input
  assert property (@(posedge clk) rst |=> !result_valid && !box_stall)
    else $error("state left after reset");

  // row registers never refuse a write
  assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("config write refused");

  // box_stall is expected only after result_stall was high
  assert property (@(posedge clk) disable iff (rst) $past(!result_stall) |-> !box_stall)
    else $error("input stalled without back pressure");

  // box_valid is seen only through the handshake
  assert property (@(posedge clk) disable iff (rst) box_stall |-> $past(box_valid) || $past(box_stall))
    else $error("stall without a pending box");

endmodule

bind frustum_aabb_cull_test fac_checker u_fac_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .box_valid    (box_valid),
  .box_stall    (box_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .inside_res   (inside_res)
);
